// File: rtl/trqd_pkg.sv
// trqd_pkg: shared types and constants of the timed release queue.
// Used by the channel interfaces and every module of the block; no dependencies.
package trqd_pkg;

  // input item codes
  localparam logic [1:0] OP_LOCAL  = 2'd0;
  localparam logic [1:0] OP_PACKET = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_RESET  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_APPLY  = 2'd0;
  localparam logic [1:0] KIND_SEND   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // register indexes on the APB port (byte address = 4 * index)
  localparam logic [2:0] REG_NETWORKED    = 3'd0;
  localparam logic [2:0] REG_LOCAL_PLAYER = 3'd1;
  localparam logic [2:0] REG_LOCAL_HERO   = 3'd2;
  localparam logic [2:0] REG_LEAD_FRAMES  = 3'd3;
  localparam logic [2:0] REG_MATCH_TYPE   = 3'd4;

  localparam int ADDR_W   = 5;
  localparam int FRAME_W  = 31;
  localparam int SERIAL_W = 32;
  localparam int ORIGIN_W = 4;   // holds any player index up to sixteen players
  localparam int CMP_W    = 33;  // signed compare width, covers 32-bit signed and 31-bit frames

  localparam logic [FRAME_W-1:0] FRAME_MAX       = {FRAME_W{1'b1}};
  localparam logic [15:0]        MIN_PACKET_SIZE = 16'd33;
  localparam logic [7:0]         LEAD_RESET      = 8'd12;

  typedef struct packed {
    logic       networked;
    logic [1:0] local_player;
    logic [1:0] local_hero;
    logic [7:0] lead_frames;
    logic [7:0] match_type;
  } cfg_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame;
    logic [SERIAL_W-1:0] serial;
    logic [7:0]          hero;
    logic [7:0]          action;
    logic [7:0]          category;
    logic [7:0]          direction;
    logic [ORIGIN_W-1:0] origin;
  } entry_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [1:0]          hero;
    logic [7:0]          action;
    logic [7:0]          category;
    logic [7:0]          direction;
    logic [FRAME_W-1:0]  frame;
    logic [1:0]          origin;
    logic [SERIAL_W-1:0] serial;
    logic                consumed;
    logic                late;
    logic                dropped;
    logic                last;
  } res_t;

endpackage

// File: rtl/trqd_if.sv
// trqd_if: valid/ready channel interfaces for input items and results.
// Depends on trqd_pkg for field widths.
interface trqd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           op;
  logic [7:0]                           action;
  logic signed [7:0]                    category;
  logic signed [7:0]                    direction;
  logic [trqd_pkg::FRAME_W-1:0]         frame;
  logic signed [7:0]                    origin_player;
  logic signed [trqd_pkg::SERIAL_W-1:0] serial;
  logic signed [7:0]                    hero;
  logic [trqd_pkg::FRAME_W-1:0]         apply_frame;
  logic [7:0]                           packet_type;
  logic [15:0]                          packet_size;

  modport source (output valid, op, action, category, direction, frame, origin_player,
                  serial, hero, apply_frame, packet_type, packet_size, input ready);
  modport sink   (input valid, op, action, category, direction, frame, origin_player,
                  serial, hero, apply_frame, packet_type, packet_size, output ready);
endinterface

interface trqd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           kind;
  logic [1:0]                           out_hero;
  logic [7:0]                           out_action;
  logic signed [7:0]                    out_category;
  logic signed [7:0]                    out_direction;
  logic [trqd_pkg::FRAME_W-1:0]         out_frame;
  logic [1:0]                           out_origin;
  logic signed [trqd_pkg::SERIAL_W-1:0] out_serial;
  logic                                 consumed;
  logic                                 late;
  logic                                 dropped;
  logic                                 last;

  modport source (output valid, kind, out_hero, out_action, out_category, out_direction,
                  out_frame, out_origin, out_serial, consumed, late, dropped, last,
                  input ready);
  modport sink   (input valid, kind, out_hero, out_action, out_category, out_direction,
                  out_frame, out_origin, out_serial, consumed, late, dropped, last,
                  output ready);
endinterface

// File: rtl/trqd_cfg_regs.sv
// trqd_cfg_regs: APB register file for the queue's configuration.
// Depends on trqd_pkg (cfg_t, register indexes).
module trqd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trqd_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output trqd_pkg::cfg_t                cfg
);

  trqd_pkg::cfg_t cfg_r, cfg_nxt;
  logic [2:0]     reg_idx;

  assign reg_idx = paddr[trqd_pkg::ADDR_W-1:2];
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      unique case (reg_idx)
        trqd_pkg::REG_NETWORKED:    cfg_nxt.networked    = pwdata[0];
        trqd_pkg::REG_LOCAL_PLAYER: cfg_nxt.local_player = pwdata[1:0];
        trqd_pkg::REG_LOCAL_HERO:   cfg_nxt.local_hero   = pwdata[1:0];
        trqd_pkg::REG_LEAD_FRAMES:  cfg_nxt.lead_frames  = pwdata[7:0];
        trqd_pkg::REG_MATCH_TYPE:   cfg_nxt.match_type   = pwdata[7:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      trqd_pkg::REG_NETWORKED:    prdata = {31'd0, cfg_r.networked};
      trqd_pkg::REG_LOCAL_PLAYER: prdata = {30'd0, cfg_r.local_player};
      trqd_pkg::REG_LOCAL_HERO:   prdata = {30'd0, cfg_r.local_hero};
      trqd_pkg::REG_LEAD_FRAMES:  prdata = {24'd0, cfg_r.lead_frames};
      trqd_pkg::REG_MATCH_TYPE:   prdata = {24'd0, cfg_r.match_type};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.networked    <= 1'b0;
      cfg_r.local_player <= 2'd0;
      cfg_r.local_hero   <= 2'd0;
      cfg_r.lead_frames  <= trqd_pkg::LEAD_RESET;
      cfg_r.match_type   <= 8'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/trqd_queue_mem.sv
// trqd_queue_mem: entry store of the pending queue, one write and one
// registered read port. Depends on trqd_pkg (entry_t).
module trqd_queue_mem #(
  parameter int QUEUE_DEPTH = 16,
  parameter int IDX_W       = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IDX_W-1:0]     waddr,
  input  trqd_pkg::entry_t     wdata,
  input  logic [IDX_W-1:0]     raddr,
  output trqd_pkg::entry_t     rdata
);

  trqd_pkg::entry_t mem [QUEUE_DEPTH];
  trqd_pkg::entry_t rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// File: rtl/trqd_cmp.sv
// trqd_cmp: shared signed magnitude comparator, used for serial staleness
// checks and for the due test of each entry during a tick walk. Depends on trqd_pkg.
module trqd_cmp (
  input  logic [trqd_pkg::CMP_W-1:0] a,
  input  logic [trqd_pkg::CMP_W-1:0] b,
  output logic                       lt,
  output logic                       eq
);

  assign lt = $signed(a) < $signed(b);
  assign eq = (a == b);

endmodule

// File: rtl/trqd_ctrl.sv
// trqd_ctrl: sequencer of the queue: request stamping, packet filtering,
// the tick walk with compaction, and the staged result register.
// Depends on trqd_pkg, trqd_if; drives trqd_queue_mem and trqd_cmp.
module trqd_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_PLAYERS = 4,
  parameter int IDX_W       = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  trqd_pkg::cfg_t                 cfg,
  trqd_in_if.sink                        in_ch,
  trqd_out_if.source                     out_ch,
  output logic                           mem_we,
  output logic [IDX_W-1:0]               mem_waddr,
  output trqd_pkg::entry_t               mem_wdata,
  output logic [IDX_W-1:0]               mem_raddr,
  input  trqd_pkg::entry_t               mem_rdata,
  output logic [trqd_pkg::CMP_W-1:0]     cmp_a,
  output logic [trqd_pkg::CMP_W-1:0]     cmp_b,
  input  logic                           cmp_lt,
  input  logic                           cmp_eq
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PL_W  = $clog2(NUM_PLAYERS);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [CNT_W-1:0]              kept_r, kept_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic [trqd_pkg::SERIAL_W-1:0] own_r, own_nxt;
  logic                          late_seen_r, late_seen_nxt;
  logic [trqd_pkg::SERIAL_W-1:0] top_r [NUM_PLAYERS];
  logic [trqd_pkg::SERIAL_W-1:0] top_nxt [NUM_PLAYERS];
  logic [trqd_pkg::FRAME_W-1:0]  tick_frame_r, tick_frame_nxt;
  trqd_pkg::res_t                stg_r, stg_nxt, out_r, out_nxt;
  logic                          stg_v_r, stg_v_nxt, out_v_r, out_v_nxt;

  logic                          in_fire, out_free, full;
  logic [trqd_pkg::SERIAL_W:0]   stamp_sum;
  logic [trqd_pkg::FRAME_W-1:0]  stamp;
  logic                          hero_ok_local, pkt_match, org_ok;
  logic [PL_W-1:0]               org_idx;
  logic [trqd_pkg::SERIAL_W-1:0] top_sel;
  trqd_pkg::entry_t              q;
  logic                          pending, send, apply, need, adv, late_bit, hero_ok_q;
  trqd_pkg::res_t                res;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_v_r || out_ch.ready;
  assign full        = (count_r == CNT_FULL);
  assign q           = mem_rdata;

  assign out_ch.valid         = out_v_r;
  assign out_ch.kind          = out_r.kind;
  assign out_ch.out_hero      = out_r.hero;
  assign out_ch.out_action    = out_r.action;
  assign out_ch.out_category  = out_r.category;
  assign out_ch.out_direction = out_r.direction;
  assign out_ch.out_frame     = out_r.frame;
  assign out_ch.out_origin    = out_r.origin;
  assign out_ch.out_serial    = out_r.serial;
  assign out_ch.consumed      = out_r.consumed;
  assign out_ch.late          = out_r.late;
  assign out_ch.dropped       = out_r.dropped;
  assign out_ch.last          = out_r.last;

  // stamp = frame + lead, saturating at the largest frame
  assign stamp_sum = {2'b00, in_ch.frame} + {25'd0, cfg.lead_frames};
  assign stamp     = stamp_sum[trqd_pkg::FRAME_W] ? trqd_pkg::FRAME_MAX
                                                  : stamp_sum[trqd_pkg::FRAME_W-1:0];

  assign hero_ok_local = int'(cfg.local_hero) < NUM_PLAYERS;
  assign pkt_match     = (in_ch.packet_size >= trqd_pkg::MIN_PACKET_SIZE) &&
                         (in_ch.packet_type == cfg.match_type);
  assign org_ok        = (int'(in_ch.origin_player) >= 0) &&
                         (int'(in_ch.origin_player) < NUM_PLAYERS);
  assign org_idx       = in_ch.origin_player[PL_W-1:0];
  assign top_sel       = org_ok ? top_r[org_idx] : '0;

  // comparator: packet serial vs. highest seen, or tick frame vs. entry frame
  always_comb begin
    if (state_r == S_WALK) begin
      cmp_a = {2'b00, tick_frame_r};
      cmp_b = {2'b00, q.frame};
    end else begin
      cmp_a = {in_ch.serial[trqd_pkg::SERIAL_W-1], in_ch.serial};
      cmp_b = {top_sel[trqd_pkg::SERIAL_W-1], top_sel};
    end
  end

  assign hero_ok_q = (int'($signed(q.hero)) >= 0) && (int'($signed(q.hero)) < NUM_PLAYERS);
  assign pending   = cmp_lt;
  assign send      = pending && cfg.networked &&
                     (q.origin == trqd_pkg::ORIGIN_W'(cfg.local_player));
  assign apply     = !pending && hero_ok_q;
  assign need      = send || apply;
  assign adv       = !need || !stg_v_r || out_free;
  assign late_bit  = !pending && !cmp_lt && !cmp_eq && !late_seen_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    kept_nxt       = kept_r;
    idx_nxt        = idx_r;
    own_nxt        = own_r;
    late_seen_nxt  = late_seen_r;
    top_nxt        = top_r;
    tick_frame_nxt = tick_frame_r;
    stg_nxt        = stg_r;
    stg_v_nxt      = stg_v_r;
    out_nxt        = out_r;
    out_v_nxt      = out_v_r && !out_ch.ready;
    mem_we         = 1'b0;
    mem_waddr      = count_r[IDX_W-1:0];
    mem_wdata      = '0;
    mem_raddr      = '0;
    res            = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.op)
            trqd_pkg::OP_LOCAL: begin
              res.hero      = cfg.local_hero;
              res.action    = in_ch.action;
              res.category  = in_ch.category;
              res.direction = in_ch.direction;
              res.origin    = cfg.local_player;
              if (!cfg.networked) begin
                res.kind  = trqd_pkg::KIND_APPLY;
                res.frame = in_ch.frame;
                if (hero_ok_local) begin
                  stg_nxt   = res;
                  stg_v_nxt = 1'b1;
                  state_nxt = S_FIN;
                end
              end else begin
                res.kind    = trqd_pkg::KIND_SEND;
                res.frame   = stamp;
                res.serial  = own_r;
                res.dropped = full;
                own_nxt     = own_r + 1'b1;
                mem_wdata.frame     = stamp;
                mem_wdata.serial    = own_r;
                mem_wdata.hero      = {6'd0, cfg.local_hero};
                mem_wdata.action    = in_ch.action;
                mem_wdata.category  = in_ch.category;
                mem_wdata.direction = in_ch.direction;
                mem_wdata.origin    = trqd_pkg::ORIGIN_W'(cfg.local_player);
                if (!full) begin
                  mem_we    = 1'b1;
                  count_nxt = count_r + 1'b1;
                end
                stg_nxt   = res;
                stg_v_nxt = 1'b1;
                state_nxt = S_FIN;
              end
            end
            trqd_pkg::OP_PACKET: begin
              res.kind     = trqd_pkg::KIND_STATUS;
              res.consumed = pkt_match;
              mem_wdata.frame     = in_ch.apply_frame;
              mem_wdata.serial    = in_ch.serial;
              mem_wdata.hero      = in_ch.hero;
              mem_wdata.action    = in_ch.action;
              mem_wdata.category  = in_ch.category;
              mem_wdata.direction = in_ch.direction;
              mem_wdata.origin    = in_ch.origin_player[trqd_pkg::ORIGIN_W-1:0];
              // fresh serial: strictly above the origin's highest
              if (pkt_match && org_ok && !cmp_lt && !cmp_eq) begin
                top_nxt[org_idx] = in_ch.serial;
                if (full) begin
                  res.dropped = 1'b1;
                end else begin
                  mem_we    = 1'b1;
                  count_nxt = count_r + 1'b1;
                end
              end
              stg_nxt   = res;
              stg_v_nxt = 1'b1;
              state_nxt = S_FIN;
            end
            trqd_pkg::OP_TICK: begin
              tick_frame_nxt = in_ch.frame;
              idx_nxt        = '0;
              kept_nxt       = '0;
              if (count_r != '0) begin
                state_nxt = S_WALK;
              end
            end
            trqd_pkg::OP_RESET: begin
              count_nxt     = '0;
              own_nxt       = trqd_pkg::SERIAL_W'(1);
              late_seen_nxt = 1'b0;
              for (int p = 0; p < NUM_PLAYERS; p++) begin
                top_nxt[p] = '0;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_WALK: begin
        mem_raddr = adv ? idx_r + 1'b1 : idx_r;
        res.kind      = send ? trqd_pkg::KIND_SEND : trqd_pkg::KIND_APPLY;
        res.hero      = q.hero[1:0];
        res.action    = q.action;
        res.category  = q.category;
        res.direction = q.direction;
        res.frame     = q.frame;
        res.origin    = q.origin[1:0];
        res.serial    = q.serial;
        res.late      = late_bit;
        if (adv) begin
          if (pending) begin
            mem_we    = 1'b1;
            mem_waddr = kept_r[IDX_W-1:0];
            mem_wdata = q;
            kept_nxt  = kept_r + 1'b1;
          end else if (late_bit) begin
            late_seen_nxt = 1'b1;
          end
          if (need) begin
            // earlier staged result is not the last one: push it out
            if (stg_v_r) begin
              out_nxt      = stg_r;
              out_nxt.last = 1'b0;
              out_v_nxt    = 1'b1;
            end
            stg_nxt   = res;
            stg_v_nxt = 1'b1;
          end
          if ({1'b0, idx_r} == CNT_W'(count_r - 1'b1)) begin
            count_nxt = kept_nxt;
            state_nxt = S_FIN;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      S_FIN: begin
        if (!stg_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_nxt      = stg_r;
          out_nxt.last = 1'b1;
          out_v_nxt    = 1'b1;
          stg_v_nxt    = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      kept_r      <= '0;
      idx_r       <= '0;
      own_r       <= trqd_pkg::SERIAL_W'(1);
      late_seen_r <= 1'b0;
      stg_v_r     <= 1'b0;
      out_v_r     <= 1'b0;
      for (int p = 0; p < NUM_PLAYERS; p++) begin
        top_r[p] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      kept_r      <= kept_nxt;
      idx_r       <= idx_nxt;
      own_r       <= own_nxt;
      late_seen_r <= late_seen_nxt;
      stg_v_r     <= stg_v_nxt;
      out_v_r     <= out_v_nxt;
      top_r       <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tick_frame_r <= tick_frame_nxt;
    stg_r        <= stg_nxt;
    out_r        <= out_nxt;
  end

endmodule

// File: rtl/timed_release_queue_dedup_unit.sv
// timed_release_queue_dedup_unit: top level of the frame-stamped request queue.
// Depends on trqd_pkg, trqd_if, trqd_cfg_regs, trqd_queue_mem, trqd_cmp, trqd_ctrl.
//
// Takes one input item at a time; in_ch.ready is high only while the sequencer is
// idle. A local request or a received packet is accepted, then its single result
// is handed off to the output register. A frame tick walks the queued entries,
// reading one entry per cycle, while no result is stalled, from the queue memory
// through its single registered read port; it compacts kept entries through its
// write port and runs each entry through the shared comparator. A reset item or
// a tick on an empty queue leaves the sequencer idle. The sequencer stalls while a
// result cannot move because the output register is still full. Results are delayed
// by one staging register so the last one of each input can be marked; the next
// item is accepted while the final result still waits in the output register.
module timed_release_queue_dedup_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_PLAYERS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  trqd_in_if.sink                     in_ch,
  trqd_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [trqd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  trqd_pkg::cfg_t                cfg;
  logic                          mem_we;
  logic [IDX_W-1:0]              mem_waddr, mem_raddr;
  trqd_pkg::entry_t              mem_wdata, mem_rdata;
  logic [trqd_pkg::CMP_W-1:0]    cmp_a, cmp_b;
  logic                          cmp_lt, cmp_eq;

  trqd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  trqd_queue_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  trqd_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt),
    .eq (cmp_eq)
  );

  trqd_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_PLAYERS (NUM_PLAYERS),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .cmp_a     (cmp_a),
    .cmp_b     (cmp_b),
    .cmp_lt    (cmp_lt),
    .cmp_eq    (cmp_eq)
  );

endmodule

// File: rtl/trqd_checker.sv
// trqd_checker: port-level assertions on the queue top level, and the bind
// that attaches them. Depends on trqd_pkg and timed_release_queue_dedup_unit.
module trqd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [31:0] out_serial,
  input logic        consumed,
  input logic        late,
  input logic        dropped,
  input logic        last
);

  // a packet status is always a single, last result with no request payload
  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == trqd_pkg::KIND_STATUS |-> last && !late && out_serial == 32'd0)
    else $error("status result malformed");

  // the late flag only rides on a queue apply
  a_late_apply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && late |-> kind == trqd_pkg::KIND_APPLY && !consumed && !dropped)
    else $error("late flag on a result that is not a queue apply");

  // in the cycle after a packet transfer the sequencer is busy
  a_packet_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == trqd_pkg::OP_PACKET |=> !in_ready)
    else $error("input accepted right after a packet");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last))
    else $error("stalled result changed");

endmodule

bind timed_release_queue_dedup_unit trqd_checker u_trqd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_op      (in_ch.op),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .kind       (out_ch.kind),
  .out_serial (out_ch.out_serial),
  .consumed   (out_ch.consumed),
  .late       (out_ch.late),
  .dropped    (out_ch.dropped),
  .last       (out_ch.last)
);

// File: verif/timed_release_queue_dedup_unit_tb.sv
// Self-checking bench for timed_release_queue_dedup_unit: directed items, then random phases.
// Tracks queue, serials and late flag alongside the block and checks every result transfer.
// Depends on trqd_pkg, trqd_if and the block's RTL.
`timescale 1ns / 1ps

module timed_release_queue_dedup_unit_tb;
  import trqd_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int NPLAYERS    = 4;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    logic [1:0]         op;
    logic [7:0]         action;
    logic signed [7:0]  category;
    logic signed [7:0]  direction;
    logic [FRAME_W-1:0] frame;
    logic signed [7:0]  origin_player;
    logic signed [31:0] serial;
    logic signed [7:0]  hero;
    logic [FRAME_W-1:0] apply_frame;
    logic [7:0]         packet_type;
    logic [15:0]        packet_size;
  } stim_t;

  // Mirrors the queue, per-player serial high marks and late flag; holds the
  // results still owed by the block, oldest first.
  class queue_release_tracker;
    cfg_t        cfg;
    entry_t      slots[QDEPTH];
    int unsigned held;
    logic [31:0] top_ser[NPLAYERS];
    logic [31:0] next_own;
    bit          late_done;
    res_t        owed[$];
    int          errors;
    int          checked;

    function new();
      cfg = '0;
      cfg.lead_frames = LEAD_RESET;
      clear_protocol();
      errors = 0;
      checked = 0;
    endfunction

    function void clear_protocol();
      held = 0;
      next_own = 1;
      late_done = 0;
      foreach (top_ser[p]) top_ser[p] = '0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_NETWORKED:    cfg.networked = value[0];
        REG_LOCAL_PLAYER: cfg.local_player = value[1:0];
        REG_LOCAL_HERO:   cfg.local_hero = value[1:0];
        REG_LEAD_FRAMES:  cfg.lead_frames = value[7:0];
        REG_MATCH_TYPE:   cfg.match_type = value[7:0];
        default: ;
      endcase
    endfunction

    function bit store_entry(entry_t e);
      if (held >= QDEPTH) return 0;
      slots[held] = e;
      held++;
      return 1;
    endfunction

    function res_t request_result(logic [1:0] kind, entry_t e, logic late, logic dropped);
      res_t r;
      r = '0;
      r.kind      = kind;
      r.hero      = e.hero[1:0];
      r.action    = e.action;
      r.category  = e.category;
      r.direction = e.direction;
      r.frame     = e.frame;
      r.origin    = e.origin[1:0];
      r.serial    = e.serial;
      r.late      = late;
      r.dropped   = dropped;
      return r;
    endfunction

    function void take_item(stim_t it);
      res_t        batch[$];
      res_t        st;
      entry_t      e;
      logic [31:0] stamp;
      int unsigned kept;
      logic        late;
      logic [1:0]  idx;
      bit          ok;
      e = '0;
      e.action    = it.action;
      e.category  = it.category;
      e.direction = it.direction;
      case (it.op)
        OP_LOCAL: begin
          e.hero   = {6'd0, cfg.local_hero};
          e.origin = {2'd0, cfg.local_player};
          if (!cfg.networked) begin
            e.frame  = it.frame;
            e.serial = '0;
            batch.push_back(request_result(KIND_APPLY, e, 1'b0, 1'b0));
          end else begin
            stamp    = {1'b0, it.frame} + cfg.lead_frames;
            e.frame  = stamp[31] ? FRAME_MAX : stamp[FRAME_W-1:0];
            e.serial = next_own;
            next_own = next_own + 1;
            ok = store_entry(e);
            batch.push_back(request_result(KIND_SEND, e, 1'b0, !ok));
          end
        end
        OP_PACKET: begin
          st = '0;
          st.kind = KIND_STATUS;
          if (it.packet_size >= MIN_PACKET_SIZE && it.packet_type == cfg.match_type) begin
            st.consumed = 1'b1;
            if (it.origin_player >= 0 && it.origin_player < NPLAYERS) begin
              idx = it.origin_player[1:0];
              if (it.serial > $signed(top_ser[idx])) begin
                top_ser[idx] = it.serial;
                e.origin = {2'd0, idx};
                e.serial = it.serial;
                e.hero   = it.hero;
                e.frame  = it.apply_frame;
                st.dropped = !store_entry(e);
              end
            end
          end
          batch.push_back(st);
        end
        OP_TICK: begin
          kept = 0;
          for (int i = 0; i < held; i++) begin
            e = slots[i];
            if (it.frame < e.frame) begin
              if (cfg.networked && e.origin == {2'd0, cfg.local_player})
                batch.push_back(request_result(KIND_SEND, e, 1'b0, 1'b0));
              slots[kept] = e;
              kept++;
            end else begin
              late = 1'b0;
              if (e.frame < it.frame && !late_done) begin
                late_done = 1;
                late = 1'b1;
              end
              // out-of-range hero still leaves the queue, just silently
              if ($signed(e.hero) >= 0 && $signed(e.hero) < NPLAYERS)
                batch.push_back(request_result(KIND_APPLY, e, late, 1'b0));
            end
          end
          held = kept;
        end
        default: clear_protocol();
      endcase
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[k]) owed.push_back(batch[k]);
    endfunction

    task report(string msg);
      if (errors < 50) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(res_t got);
      res_t  want;
      string bad;
      checked++;
      if (owed.size() == 0) begin
        report($sformatf("result %0d arrived with nothing owed: %h", checked, got));
        return;
      end
      want = owed.pop_front();
      bad = "";
      if (got.kind !== want.kind)           bad = {bad, " kind"};
      if (got.hero !== want.hero)           bad = {bad, " hero"};
      if (got.action !== want.action)       bad = {bad, " action"};
      if (got.category !== want.category)   bad = {bad, " category"};
      if (got.direction !== want.direction) bad = {bad, " direction"};
      if (got.frame !== want.frame)         bad = {bad, " frame"};
      if (got.origin !== want.origin)       bad = {bad, " origin"};
      if (got.serial !== want.serial)       bad = {bad, " serial"};
      if (got.consumed !== want.consumed)   bad = {bad, " consumed"};
      if (got.late !== want.late)           bad = {bad, " late"};
      if (got.dropped !== want.dropped)     bad = {bad, " dropped"};
      if (got.last !== want.last)           bad = {bad, " last"};
      if (bad != "")
        report($sformatf("result %0d differs in%s: got %h want %h", checked, bad, got, want));
    endtask

    task flush_leftovers();
      while (owed.size() > 0) begin
        report($sformatf("result never arrived: %h", owed.pop_front()));
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  trqd_in_if  in_ch();
  trqd_out_if out_ch();

  timed_release_queue_dedup_unit #(
    .QUEUE_DEPTH(QDEPTH),
    .NUM_PLAYERS(NPLAYERS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  queue_release_tracker tracker = new();

  bit                 calm;
  bit                 hold_out;
  logic [FRAME_W-1:0] now;
  int                 serial_head[NPLAYERS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #(5_000_000);
    $display("== FAIL ==");
    $finish;
  end

  // result side backpressure; the long hold is counted here
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 11);
    end
  end

  initial begin
    res_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.kind      = out_ch.kind;
        got.hero      = out_ch.out_hero;
        got.action    = out_ch.out_action;
        got.category  = out_ch.out_category;
        got.direction = out_ch.out_direction;
        got.frame     = out_ch.out_frame;
        got.origin    = out_ch.out_origin;
        got.serial    = out_ch.out_serial;
        got.consumed  = out_ch.consumed;
        got.late      = out_ch.late;
        got.dropped   = out_ch.dropped;
        got.last      = out_ch.last;
        tracker.check_result(got);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, value);
  endtask

  // wait out every owed result, then a tick walk that may report nothing
  task automatic settle();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (tracker.owed.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (QDEPTH + 8) @(posedge clk);
  endtask

  task automatic set_phase(int net, int lp, int lh, int lead, int mt);
    settle();
    write_reg(REG_NETWORKED, net);
    write_reg(REG_LOCAL_PLAYER, lp);
    write_reg(REG_LOCAL_HERO, lh);
    write_reg(REG_LEAD_FRAMES, lead);
    write_reg(REG_MATCH_TYPE, mt);
  endtask

  task automatic offer(stim_t it);
    if (!calm && $urandom_range(0, 99) < 11) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= it.op;
    in_ch.action        <= it.action;
    in_ch.category      <= it.category;
    in_ch.direction     <= it.direction;
    in_ch.frame         <= it.frame;
    in_ch.origin_player <= it.origin_player;
    in_ch.serial        <= it.serial;
    in_ch.hero          <= it.hero;
    in_ch.apply_frame   <= it.apply_frame;
    in_ch.packet_type   <= it.packet_type;
    in_ch.packet_size   <= it.packet_size;
    do @(posedge clk); while (!in_ch.ready);
    tracker.take_item(it);
  endtask

  function automatic stim_t blank(logic [1:0] op);
    stim_t it;
    it.op            = op;
    it.action        = '0;
    it.category      = '0;
    it.direction     = '0;
    it.frame         = now;
    it.origin_player = '0;
    it.serial        = '0;
    it.hero          = '0;
    it.apply_frame   = '0;
    it.packet_type   = '0;
    it.packet_size   = '0;
    return it;
  endfunction

  function automatic stim_t req(logic [FRAME_W-1:0] f, int act, int cat, int dir);
    stim_t it;
    it = blank(OP_LOCAL);
    it.frame     = f;
    it.action    = act;
    it.category  = cat;
    it.direction = dir;
    return it;
  endfunction

  function automatic stim_t pkt(int org, int ser, int hero, int af, int size, int ptype);
    stim_t it;
    it = blank(OP_PACKET);
    it.origin_player = org;
    it.serial        = ser;
    it.hero          = hero;
    it.apply_frame   = af;
    it.packet_size   = size;
    it.packet_type   = ptype;
    it.action        = $urandom;
    it.category      = $urandom;
    it.direction     = $urandom;
    return it;
  endfunction

  function automatic stim_t tick(logic [FRAME_W-1:0] f);
    stim_t it;
    it = blank(OP_TICK);
    it.frame = f;
    return it;
  endfunction

  function automatic void advance(int unsigned d);
    if (FRAME_MAX - now < d) now = FRAME_MAX;
    else now = now + d;
  endfunction

  function automatic stim_t random_item();
    stim_t it;
    int    pick;
    int    org;
    it = blank(OP_TICK);
    it.action    = $urandom;
    it.category  = $urandom;
    it.direction = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // noise: every field free
      it.op            = $urandom;
      it.frame         = $urandom;
      it.origin_player = $urandom;
      it.serial        = $urandom;
      it.hero          = $urandom;
      it.apply_frame   = $urandom;
      it.packet_type   = $urandom;
      it.packet_size   = $urandom;
    end else if (pick < 42) begin
      it.op = OP_LOCAL;
    end else if (pick < 80) begin
      it.op = OP_PACKET;
      org = $urandom_range(0, NPLAYERS - 1);
      // mostly fresh serials, now and then a repeat that must be suppressed
      if ($urandom_range(0, 9) != 0) serial_head[org] += $urandom_range(1, 3);
      it.origin_player = org;
      it.serial        = serial_head[org];
      it.hero          = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, NPLAYERS - 1);
      it.apply_frame   = now + $urandom_range(0, 24);
      it.packet_type   = tracker.cfg.match_type;
      it.packet_size   = $urandom_range(33, 200);
      case ($urandom_range(0, 15))
        0: it.packet_size = $urandom_range(0, 32);
        1: it.packet_type = ~tracker.cfg.match_type;
        2: it.origin_player = $urandom_range(4, 127);
        default: ;
      endcase
    end else if (pick < 98) begin
      advance($urandom_range(0, 6));
      it.frame = now;
    end else begin
      it.op = OP_RESET;
    end
    return it;
  endfunction

  task automatic run_phase(int count);
    int    k;
    stim_t it;
    k = 0;
    while (k < count) begin
      if ($urandom_range(0, 24) == 0) begin
        // overfill the queue, then release the lot in one tick
        repeat (QDEPTH + 2) begin
          it = random_item();
          if (it.op == OP_TICK || it.op == OP_RESET) it.op = OP_LOCAL;
          offer(it);
          k++;
        end
        advance(300);
        offer(tick(now));
        k++;
      end else begin
        offer(random_item());
        k++;
      end
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.op            <= OP_RESET;
    in_ch.action        <= '0;
    in_ch.category      <= '0;
    in_ch.direction     <= '0;
    in_ch.frame         <= '0;
    in_ch.origin_player <= '0;
    in_ch.serial        <= '0;
    in_ch.hero          <= '0;
    in_ch.apply_frame   <= '0;
    in_ch.packet_type   <= '0;
    in_ch.packet_size   <= '0;
    calm     = 1'b0;
    hold_out = 1'b0;
    now      = 31'd1000;
    foreach (serial_head[p]) serial_head[p] = $urandom_range(1, 1000);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // immediate apply while not networked
    set_phase(0, 3, 2, 12, 8'hA5);
    offer(req(0, 8'h00, -128, 127));
    offer(req(FRAME_MAX, 8'hFF, 127, -128));

    set_phase(1, 3, 2, 255, 8'hA5);
    offer(req(FRAME_MAX - 10, 8'h5A, -1, 1));   // stamp saturates
    offer(req(100, 8'hA5, 0, -1));
    offer(pkt(0, 1, 0, 0, 32, 8'hA5));          // too short
    offer(pkt(0, 1, 0, 0, 33, 8'hA4));          // wrong type
    offer(pkt(-1, 1, 0, 0, 33, 8'hA5));         // origin out of range
    offer(pkt(4, 1, 0, 0, 33, 8'hA5));
    offer(pkt(0, 5, 1, 50, 33, 8'hA5));
    offer(pkt(0, 5, 2, 50, 33, 8'hA5));         // equal serial is stale
    offer(pkt(1, -5, 0, 50, 33, 8'hA5));        // negative serial is stale
    offer(pkt(2, 32'h7FFF_FFFF, -1, 40, 16'hFFFF, 8'hA5));
    offer(pkt(3, 1, 5, 60, 100, 8'hA5));
    offer(tick(10));                            // resends only
    offer(tick(55));                            // overdue release, bad hero skipped
    offer(tick(60));                            // exactly due, bad hero
    offer(blank(OP_RESET));
    offer(tick(61));                            // nothing queued
    offer(pkt(1, 3, 100, 5, 40, 8'hA5));        // overdue with bad hero takes the late flag
    offer(pkt(1, 4, 2, 5, 40, 8'hA5));
    offer(tick(9));

    set_phase(1, 0, 0, 0, 0);
    calm = 1'b1;
    run_phase(45);
    calm = 1'b0;

    set_phase(1, 1, 3, 255, 255);
    hold_out = 1'b1;
    run_phase(45);

    set_phase(0, 2, 1, $urandom_range(0, 255), $urandom_range(0, 255));
    run_phase(30);

    now = FRAME_MAX - 300;
    set_phase(1, 3, 3, $urandom_range(0, 255), $urandom_range(0, 255));
    run_phase(45);

    now = $urandom_range(0, 1 << 24);
    set_phase(1, $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 255),
              $urandom_range(0, 255));
    run_phase(50);

    set_phase(1, $urandom_range(0, 3), $urandom_range(0, 3), 12, 8'h5A);
    run_phase(55);

    settle();
    tracker.flush_leftovers();
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
